### rtl/evhs_pkg.sv
// ----------------------------------------------------------------------------
// evhs_pkg
// shared types, widths and codes for the event history search block
// ----------------------------------------------------------------------------
package evhs_pkg;

  localparam int DEPTH_DEF = 256;

  localparam int MODE_W = 2;
  localparam int CH_W   = 10;
  localparam int VAL_W  = 32;
  localparam int TICK_W = 64;

  localparam int S_TDATA_W = 176;
  localparam int M_TDATA_W = 96;

  localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AFTER  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BEFORE = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [VAL_W-1:0]  value;
    logic [CH_W-1:0]   channel;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic hit;
    logic stop;
  } match_t;

endpackage

### rtl/event_history_search.sv
// ----------------------------------------------------------------------------
// event_history_search
// ring of timestamped event records with newest-first keyed search
// ----------------------------------------------------------------------------
// input beats on s_axis: tuser carries the mode (push, find after bound, find
// before bound), tdata the channel, value, timestamp and bound. a push writes
// the slot after the newest one and gives no output beat; mode 3 is dropped.
// a query walks the ring from the newest slot to the oldest through one
// registered read port and one compare unit, one slot per cycle, and returns
// one beat on m_axis: tuser is the found flag, tdata the hit time and value.
// s_axis_tready is low during a walk and rises again together with m_axis_tvalid
// when the result is loaded into the output register.
// after reset a clearing pass zeroes all DEPTH slots, one per cycle, with
// s_axis_tready low until the last slot has been cleared.
// when m_axis stalls the result sits in the output register and a new input
// beat is still taken; a finished walk then waits until that register frees.
// ----------------------------------------------------------------------------
module event_history_search
  import evhs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // channel, event_value, now_tick, bound_tick, zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // mode
  input  logic [MODE_W-1:0]    s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // hit_tick, hit_value
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // found
  output logic                 m_axis_tuser
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_q, state_d;

  logic [AW-1:0] clr_addr_q;
  logic [AW-1:0] newest_q;
  logic [AW-1:0] push_slot;
  logic [AW-1:0] ptr_q;
  logic [AW-1:0] issue_cnt_q;
  logic          issue_done_q;
  logic          cmp_vld_q;
  logic          cmp_last_q;

  logic [MODE_W-1:0] mode_q;
  logic [CH_W-1:0]   key_q;
  logic [TICK_W-1:0] bound_q;

  logic              res_found_q;
  logic [TICK_W-1:0] res_tick_q;
  logic [VAL_W-1:0]  res_value_q;

  logic                 m_valid_q;
  logic                 m_found_q;
  logic [M_TDATA_W-1:0] m_data_q;

  logic [MODE_W-1:0] in_mode;
  rec_t              in_rec;
  logic [TICK_W-1:0] in_bound;

  logic    in_beat;
  logic    is_query;
  logic    we;
  logic [AW-1:0] waddr;
  rec_t    wdata;
  logic    rd_en;
  rec_t    rd_rec;
  match_t  mres;
  logic    finish;
  logic    out_free;

  assign in_mode        = s_axis_tuser;
  assign in_rec.channel = s_axis_tdata[CH_W-1:0];
  assign in_rec.value   = s_axis_tdata[CH_W+VAL_W-1:CH_W];
  assign in_rec.tick    = s_axis_tdata[CH_W+VAL_W+TICK_W-1:CH_W+VAL_W];
  assign in_bound       = s_axis_tdata[CH_W+VAL_W+2*TICK_W-1:CH_W+VAL_W+TICK_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign is_query      = (in_mode == MODE_AFTER) || (in_mode == MODE_BEFORE);

  assign push_slot = (newest_q == LAST_SLOT) ? '0 : newest_q + AW'(1);

  always_comb begin
    if (state_q == ST_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr_q;
      wdata = '0;
    end else begin
      we    = in_beat && (in_mode == MODE_PUSH);
      waddr = push_slot;
      wdata = in_rec;
    end
  end

  assign finish   = (state_q == ST_SEARCH) && cmp_vld_q && (mres.stop || cmp_last_q);
  assign rd_en    = (state_q == ST_SEARCH) && !issue_done_q && !finish;
  assign out_free = !m_valid_q || m_axis_tready;

  evhs_ram #(
    .DEPTH(DEPTH),
    .WIDTH(REC_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (rd_en),
    .raddr_i(ptr_q),
    .rdata_o(rd_rec)
  );

  evhs_match u_match (
    .mode_i (mode_q),
    .key_i  (key_q),
    .bound_i(bound_q),
    .rec_i  (rd_rec),
    .res_o  (mres)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_addr_q == LAST_SLOT) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat && is_query) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (finish) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_addr_q   <= '0;
      newest_q     <= '0;
      ptr_q        <= '0;
      issue_cnt_q  <= '0;
      issue_done_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      cmp_last_q   <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
      if (in_beat && (in_mode == MODE_PUSH)) begin
        newest_q <= push_slot;
      end
      if (in_beat && is_query) begin
        ptr_q        <= newest_q;
        issue_cnt_q  <= '0;
        issue_done_q <= 1'b0;
      end else if (rd_en) begin
        ptr_q       <= (ptr_q == '0) ? LAST_SLOT : ptr_q - AW'(1);
        issue_cnt_q <= issue_cnt_q + AW'(1);
        if (issue_cnt_q == LAST_SLOT) begin
          issue_done_q <= 1'b1;
        end
      end
      cmp_vld_q  <= rd_en;
      cmp_last_q <= rd_en && (issue_cnt_q == LAST_SLOT);
      if ((state_q == ST_RESULT) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat && is_query) begin
      mode_q  <= in_mode;
      key_q   <= in_rec.channel;
      bound_q <= in_bound;
    end
    if (finish) begin
      res_found_q <= mres.hit;
      res_tick_q  <= mres.hit ? rd_rec.tick : '0;
      res_value_q <= mres.hit ? rd_rec.value : '0;
    end
    if ((state_q == ST_RESULT) && out_free) begin
      m_found_q <= res_found_q;
      m_data_q  <= {res_value_q, res_tick_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_found_q;

  a_cmp_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> (state_q == ST_SEARCH))
    else $error("compare data outside a walk");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss beat carries nonzero data");

  a_push_moves_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (in_mode == MODE_PUSH)) |=> (newest_q != $past(newest_q)))
    else $error("push did not advance newest slot");

  a_no_beat_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> (!m_axis_tvalid))
    else $error("output beat during clearing pass");

  a_result_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RESULT) && out_free) |=> (m_axis_tvalid && (state_q == ST_IDLE)))
    else $error("result not moved to output register");

endmodule

### rtl/evhs_ram.sv
// ----------------------------------------------------------------------------
// evhs_ram
// record store, one write port and one registered read port
// ----------------------------------------------------------------------------
module evhs_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 106
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/evhs_match.sv
// ----------------------------------------------------------------------------
// evhs_match
// shared compare unit: checks one stored record against the query key and bound
// ----------------------------------------------------------------------------
module evhs_match
  import evhs_pkg::*;
(
  input  logic [MODE_W-1:0] mode_i,
  input  logic [CH_W-1:0]   key_i,
  input  logic [TICK_W-1:0] bound_i,
  input  rec_t              rec_i,
  output match_t            res_o
);

  logic ch_eq;
  logic tick_le;
  logic tick_lt;

  assign ch_eq   = (rec_i.channel == key_i);
  assign tick_le = (rec_i.tick <= bound_i);
  assign tick_lt = tick_le && (rec_i.tick != bound_i);

  always_comb begin
    res_o = '0;
    case (mode_i)
      MODE_AFTER: begin
        res_o.hit  = !tick_le && ch_eq;
        res_o.stop = tick_le || ch_eq;
      end
      MODE_BEFORE: begin
        res_o.hit  = tick_lt && ch_eq;
        res_o.stop = tick_lt && ch_eq;
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule
